### rtl/ihc_pkg.sv
// Shared types and constants for the IPv4 header checker.
package ihc_pkg;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_SHORT     = 3'd1;
	localparam logic [2:0] ST_BAD_HLEN  = 3'd2;
	localparam logic [2:0] ST_BAD_CSUM  = 3'd3;
	localparam logic [2:0] ST_FRAG      = 3'd4;
	localparam logic [2:0] ST_NOT_ICMP  = 3'd5;

	localparam logic [15:0] MIN_LEN     = 16'd20;
	localparam logic [3:0]  MIN_WORDS   = 4'd5;
	localparam logic [7:0]  PROTO_ICMP  = 8'd1;
	localparam logic [15:0] CNT_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  version;
		logic [3:0]  header_words;
		logic [15:0] total_length;
		logic [15:0] ident;
		logic [2:0]  flag_bits;
		logic [12:0] frag_offset;
		logic [7:0]  ttl;
		logic [7:0]  protocol;
		logic [31:0] src_addr;
		logic [31:0] dest_addr;
		logic [15:0] payload_bytes;
	} result_t;

	typedef struct packed {
		logic       adv;
		logic       last;
		logic [7:0] data;
	} byte_ctl_t;

endpackage

### rtl/ihc_parse.sv
// Per-byte header capture, checksum accumulation and verdict logic.
module ihc_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  ihc_pkg::byte_ctl_t ctl,
	output ihc_pkg::result_t   res
);
	import ihc_pkg::*;

	logic [15:0] cnt_q, sum_q, tl_q, id_q;
	logic [7:0]  hold_q, ttl_q, proto_q;
	logic [3:0]  hw_q, ver_q;
	logic [2:0]  flags_q;
	logic [12:0] off_q;
	logic [31:0] src_q, dest_q;

	logic [15:0] cnt_n, sum_n, tl_n, id_n;
	logic [7:0]  hold_n, ttl_n, proto_n, b;
	logic [3:0]  hw_n, ver_n;
	logic [2:0]  flags_n;
	logic [12:0] off_n;
	logic [31:0] src_n, dest_n;
	logic [5:0]  hlen;
	logic [16:0] s;
	logic [15:0] idx;

	always_comb begin
		b       = ctl.data;
		idx     = cnt_q;
		ver_n   = ver_q;
		hw_n    = hw_q;
		tl_n    = tl_q;
		id_n    = id_q;
		flags_n = flags_q;
		off_n   = off_q;
		ttl_n   = ttl_q;
		proto_n = proto_q;
		src_n   = src_q;
		dest_n  = dest_q;
		hold_n  = hold_q;
		sum_n   = sum_q;
		s       = 17'd0;

		unique case (idx)
			16'd0: begin
				ver_n = b[7:4];
				hw_n  = b[3:0];
			end
			16'd2: tl_n[15:8] = b;
			16'd3: tl_n[7:0]  = b;
			16'd4: id_n[15:8] = b;
			16'd5: id_n[7:0]  = b;
			16'd6: begin
				flags_n     = b[7:5];
				off_n[12:8] = b[4:0];
			end
			16'd7: off_n[7:0] = b;
			16'd8: ttl_n      = b;
			16'd9: proto_n    = b;
			16'd12, 16'd13, 16'd14, 16'd15: src_n  = {src_q[23:0], b};
			16'd16, 16'd17, 16'd18, 16'd19: dest_n = {dest_q[23:0], b};
			default: ;
		endcase

		hlen = {hw_n, 2'b00};
		if (idx < {10'd0, hlen}) begin
			if (!idx[0]) begin
				hold_n = b;
			end else begin
				s     = {1'b0, sum_q} + {1'b0, hold_q, b};
				sum_n = s[15:0] + {15'd0, s[16]};
			end
		end

		cnt_n = (cnt_q != CNT_MAX) ? cnt_q + 16'd1 : cnt_q;

		priority if (cnt_n < MIN_LEN)                     res.status = ST_SHORT;
		else if (hw_n < MIN_WORDS)                         res.status = ST_BAD_HLEN;
		else if (cnt_n < {10'd0, hlen})                    res.status = ST_SHORT;
		else if (sum_n != 16'hFFFF && sum_n != 16'h0000)   res.status = ST_BAD_CSUM;
		else if (flags_n[0] || off_n != 13'd0)             res.status = ST_FRAG;
		else if (proto_n != PROTO_ICMP)                    res.status = ST_NOT_ICMP;
		else                                               res.status = ST_OK;

		res.version       = ver_n;
		res.header_words  = hw_n;
		res.total_length  = tl_n;
		res.ident         = id_n;
		res.flag_bits     = flags_n;
		res.frag_offset   = off_n;
		res.ttl           = ttl_n;
		res.protocol      = proto_n;
		res.src_addr      = src_n;
		res.dest_addr     = dest_n;
		res.payload_bytes = (cnt_n >= {10'd0, hlen}) ? cnt_n - {10'd0, hlen} : 16'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			sum_q   <= '0;
			hold_q  <= '0;
			hw_q    <= '0;
			ver_q   <= '0;
			tl_q    <= '0;
			id_q    <= '0;
			flags_q <= '0;
			off_q   <= '0;
			ttl_q   <= '0;
			proto_q <= '0;
			src_q   <= '0;
			dest_q  <= '0;
		end else if (ctl.adv) begin
			if (ctl.last) begin
				cnt_q   <= '0;
				sum_q   <= '0;
				hold_q  <= '0;
				hw_q    <= '0;
				ver_q   <= '0;
				tl_q    <= '0;
				id_q    <= '0;
				flags_q <= '0;
				off_q   <= '0;
				ttl_q   <= '0;
				proto_q <= '0;
				src_q   <= '0;
				dest_q  <= '0;
			end else begin
				cnt_q   <= cnt_n;
				sum_q   <= sum_n;
				hold_q  <= hold_n;
				hw_q    <= hw_n;
				ver_q   <= ver_n;
				tl_q    <= tl_n;
				id_q    <= id_n;
				flags_q <= flags_n;
				off_q   <= off_n;
				ttl_q   <= ttl_n;
				proto_q <= proto_n;
				src_q   <= src_n;
				dest_q  <= dest_n;
			end
		end
	end

endmodule

### rtl/ihc_out.sv
// Result register for the verdict and parsed header fields.
module ihc_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  ihc_pkg::result_t res,
	input  logic             out_stall,
	output logic             out_valid,
	output logic             room,
	output ihc_pkg::result_t res_q
);
	import ihc_pkg::*;

	logic valid_q;

	assign room      = !valid_q || !out_stall;
	assign out_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

endmodule

### rtl/ipv4_header_checker.sv
// Top level of the IPv4 header checker.
// A request's last byte is registered in the input stage, then processed and loaded into the
// result register; that load is held back only while an earlier result is stalled.
// Throughput: one byte per cycle unless in_stall is high, set by the per-byte capture and checksum add.
// Reset clears all captured fields, the byte count, the checksum and both valid flags.
module ipv4_header_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [3:0]  version,
	output logic [3:0]  header_words,
	output logic [15:0] total_length,
	output logic [15:0] ident,
	output logic [2:0]  flag_bits,
	output logic [12:0] frag_offset,
	output logic [7:0]  ttl,
	output logic [7:0]  protocol,
	output logic [31:0] src_addr,
	output logic [31:0] dest_addr,
	output logic [15:0] payload_bytes
);
	import ihc_pkg::*;

	logic       valid_s1, last_s1, adv, room;
	logic [7:0] data_s1;
	byte_ctl_t  ctl;
	result_t    res, res_q;

	assign adv      = valid_s1 && (!last_s1 || room);
	assign in_stall = valid_s1 && !adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	assign ctl.adv  = adv;
	assign ctl.last = last_s1;
	assign ctl.data = data_s1;

	ihc_parse u_parse (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.res    (res)
	);

	ihc_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv && last_s1),
		.res       (res),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.room      (room),
		.res_q     (res_q)
	);

	assign status        = res_q.status;
	assign version       = res_q.version;
	assign header_words  = res_q.header_words;
	assign total_length  = res_q.total_length;
	assign ident         = res_q.ident;
	assign flag_bits     = res_q.flag_bits;
	assign frag_offset   = res_q.frag_offset;
	assign ttl           = res_q.ttl;
	assign protocol      = res_q.protocol;
	assign src_addr      = res_q.src_addr;
	assign dest_addr     = res_q.dest_addr;
	assign payload_bytes = res_q.payload_bytes;

endmodule
